/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bts_pkg.sv */
// shared types, constants and helpers of the bilinear texture sampler
package bts_pkg;

    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int TEXEL_W     = 32;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int NUM_TAP     = 4;
    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int WEIGHT_W    = FRAC_W + 1;
    localparam int KW          = 2 * FRAC_W + 1;
    localparam int PROD_W      = KW + CH_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int SUM_SHIFT   = 2 * FRAC_W;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_W-1:0]    CFG_RESET = 9'd256;
    localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'h10000;

    // corner taps
    localparam int TAP00 = 0;
    localparam int TAP10 = 1;
    localparam int TAP01 = 2;
    localparam int TAP11 = 3;

    // channel order, red in the top byte of a texel
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef logic [ADDR_W-1:0]  tex_addr_t;
    typedef logic [TEXEL_W-1:0] texel_t;
    typedef logic [KW-1:0]      corner_wt_t;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH  = 1'b0,
        REG_TEX_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    // product of two q1.16 axis weights, never above 2^32
    function automatic corner_wt_t corner_weight(input logic [WEIGHT_W-1:0] a,
                                                 input logic [WEIGHT_W-1:0] b);
        logic [2*WEIGHT_W-1:0] prod;
        prod = a * b;
        return prod[KW-1:0];
    endfunction

endpackage

/* rtl/bts_if.sv */
// stream interfaces for sample/write items and filtered pixels
interface bts_sample_if import bts_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [ADDR_W-1:0]         texel_index;
    logic [TEXEL_W-1:0]        texel_rgba;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;

    modport source (
        output valid, action, texel_index, texel_rgba, u_coord, v_coord,
        input  ready
    );
    modport sink (
        input  valid, action, texel_index, texel_rgba, u_coord, v_coord,
        output ready
    );
endinterface

interface bts_pixel_if import bts_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;

    modport source (
        output valid, red, green, blue, alpha,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, alpha,
        output ready
    );
endinterface

/* rtl/bts_texel_mem.sv */
// texel store: two mirrored banks, one write port and two read ports each
module bts_texel_mem import bts_pkg::*;
(
    input  logic                    clk,
    input  mem_ctrl_t               ctrl,
    input  tex_addr_t               waddr,
    input  texel_t                  wdata,
    input  tex_addr_t [NUM_TAP-1:0] raddr,
    output texel_t    [NUM_TAP-1:0] rdata
);

    texel_t bank0 [STORE_DEPTH];
    texel_t bank1 [STORE_DEPTH];
    texel_t [NUM_TAP-1:0] rdata_reg;

    // both banks take every write so each holds the full texture
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            bank0[waddr] <= wdata;
            bank1[waddr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg[TAP00] <= bank0[raddr[TAP00]];
            rdata_reg[TAP10] <= bank0[raddr[TAP10]];
            rdata_reg[TAP01] <= bank1[raddr[TAP01]];
            rdata_reg[TAP11] <= bank1[raddr[TAP11]];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bilinear_texture_sampler_core.sv */
// top level: six-stage bilinear sampler with repeat wrap over a 64k-texel store
// a sample shows on the output once it has passed the registers of stages a to f in order
// throughput: one item per cycle while the output is not stalled, set by four corner reads per cycle from two
// mirrored two-read-port banks of the texel store; a write takes one slot, no result
// reset: valid bits cleared, tex_width and tex_height return to 256,
// texel store keeps its contents and is undefined until written
module bilinear_texture_sampler_core import bts_pkg::*;
#(
    parameter int MAX_DIM = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    bts_sample_if.sink           sample_in,
    bts_pixel_if.source          pixel_out
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int ROW_W = 2 * DIM_W;
    localparam int POS_W = FRAC_W + DIM_W;
    localparam logic [31:0] MAX_DIM_U = MAX_DIM;

    // zero reads as one, anything above the limit reads as the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
        logic [31:0] raw_ext;
        raw_ext = 32'(raw);
        if (raw == '0)
            eff_dim = DIM_W'(1);
        else if (raw_ext > MAX_DIM_U)
            eff_dim = DIM_W'(MAX_DIM_U);
        else
            eff_dim = DIM_W'(raw);
    endfunction

    // store index y*w+x, wrapped to the store depth
    function automatic tex_addr_t tap_addr(input logic [DIM_W-1:0] y,
                                           input logic [DIM_W-1:0] x,
                                           input logic [DIM_W-1:0] w);
        logic [ROW_W-1:0] full;
        full = ROW_W'(y) * ROW_W'(w) + ROW_W'(x);
        return ADDR_W'(full);
    endfunction

    // neighbor one further, clamped to the last column or row
    function automatic logic [DIM_W-1:0] next_clamped(input logic [DIM_W-1:0] c,
                                                      input logic [DIM_W-1:0] last);
        logic [DIM_W:0] cp1;
        cp1 = {1'b0, c} + 1'b1;
        if (cp1 < {1'b0, last})
            return cp1[DIM_W-1:0];
        else
            return last;
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] tex_width_reg;
    logic [CFG_W-1:0] tex_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= CFG_RESET;
            tex_height_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_wdata;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;
    logic [DIM_W-1:0] last_x;
    logic [DIM_W-1:0] last_y;

    // the user must change config only while idle (not enforced); so these are steady for every item in flight
    assign dim_w  = eff_dim(tex_width_reg);
    assign dim_h  = eff_dim(tex_height_reg);
    assign last_x = dim_w - 1'b1;
    assign last_y = dim_h - 1'b1;

    // ---------------------------------------------------------------
    // pipeline flow control: a stage loads when it is empty or its
    // contents move on, so bubbles collapse and a stall drops nothing
    // ---------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    logic a_free, b_free, c_free, d_free, e_free, f_free;

    assign f_free = !f_valid_reg || pixel_out.ready;
    assign e_free = !e_valid_reg || f_free;
    assign d_free = !d_valid_reg || e_free;
    assign c_free = !c_valid_reg || d_free;
    assign b_free = !b_valid_reg || c_free;
    assign a_free = !a_valid_reg || b_free;

    assign sample_in.ready = a_free;

    // ---------------------------------------------------------------
    // stage a: input register; wrap keeps only the q0.16 fraction
    // ---------------------------------------------------------------
    logic              a_action_reg;
    tex_addr_t         a_index_reg;
    texel_t            a_rgba_reg;
    logic [FRAC_W-1:0] a_fu_reg;
    logic [FRAC_W-1:0] a_fv_reg;

    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            a_action_reg <= sample_in.action;
            a_index_reg  <= sample_in.texel_index;
            a_rgba_reg   <= sample_in.texel_rgba;
            a_fu_reg     <= sample_in.u_coord[FRAC_W-1:0];
            a_fv_reg     <= sample_in.v_coord[FRAC_W-1:0];
        end
    end

    // scale the wrapped fraction by dim-1 (q9.16 position)
    logic [POS_W-1:0] a_px_next;
    logic [POS_W-1:0] a_py_next;

    assign a_px_next = POS_W'(a_fu_reg) * POS_W'(last_x);
    assign a_py_next = POS_W'(a_fv_reg) * POS_W'(last_y);

    // ---------------------------------------------------------------
    // stage b: integer corner and fraction per axis
    // ---------------------------------------------------------------
    logic              b_action_reg;
    tex_addr_t         b_index_reg;
    texel_t            b_rgba_reg;
    logic [DIM_W-1:0]  b_x0_reg;
    logic [DIM_W-1:0]  b_y0_reg;
    logic [FRAC_W-1:0] b_fx_reg;
    logic [FRAC_W-1:0] b_fy_reg;

    always_ff @(posedge clk)
    begin
        if (b_free)
        begin
            b_action_reg <= a_action_reg;
            b_index_reg  <= a_index_reg;
            b_rgba_reg   <= a_rgba_reg;
            b_x0_reg     <= a_px_next[POS_W-1:FRAC_W];
            b_y0_reg     <= a_py_next[POS_W-1:FRAC_W];
            b_fx_reg     <= a_px_next[FRAC_W-1:0];
            b_fy_reg     <= a_py_next[FRAC_W-1:0];
        end
    end

    logic [DIM_W-1:0]    b_x1;
    logic [DIM_W-1:0]    b_y1;
    logic [WEIGHT_W-1:0] b_wx0, b_wx1, b_wy0, b_wy1;
    tex_addr_t  [NUM_TAP-1:0] b_addr_next;
    corner_wt_t [NUM_TAP-1:0] b_k_next;

    always_comb
    begin
        b_x1  = next_clamped(b_x0_reg, last_x);
        b_y1  = next_clamped(b_y0_reg, last_y);
        b_wx1 = {1'b0, b_fx_reg};
        b_wy1 = {1'b0, b_fy_reg};
        b_wx0 = ONE_Q16 - b_wx1;
        b_wy0 = ONE_Q16 - b_wy1;

        b_addr_next[TAP00] = tap_addr(b_y0_reg, b_x0_reg, dim_w);
        b_addr_next[TAP10] = tap_addr(b_y0_reg, b_x1, dim_w);
        b_addr_next[TAP01] = tap_addr(b_y1, b_x0_reg, dim_w);
        b_addr_next[TAP11] = tap_addr(b_y1, b_x1, dim_w);

        // corner weights sum to exactly 2^32
        b_k_next[TAP00] = corner_weight(b_wx0, b_wy0);
        b_k_next[TAP10] = corner_weight(b_wx1, b_wy0);
        b_k_next[TAP01] = corner_weight(b_wx0, b_wy1);
        b_k_next[TAP11] = corner_weight(b_wx1, b_wy1);
    end

    // ---------------------------------------------------------------
    // stage c: store access; writes commit here so later samples in
    // the pipe always see them
    // ---------------------------------------------------------------
    logic                     c_action_reg;
    tex_addr_t                c_index_reg;
    texel_t                   c_rgba_reg;
    tex_addr_t  [NUM_TAP-1:0] c_addr_reg;
    corner_wt_t [NUM_TAP-1:0] c_k_reg;

    always_ff @(posedge clk)
    begin
        if (c_free)
        begin
            c_action_reg <= b_action_reg;
            c_index_reg  <= b_index_reg;
            c_rgba_reg   <= b_rgba_reg;
            c_addr_reg   <= b_addr_next;
            c_k_reg      <= b_k_next;
        end
    end

    mem_ctrl_t            mem_ctrl;
    texel_t [NUM_TAP-1:0] mem_rdata;

    assign mem_ctrl.wr_en = c_valid_reg && (c_action_reg == ACT_WRITE) && d_free;
    assign mem_ctrl.rd_en = d_free;

    bts_texel_mem u_texel_mem (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .waddr (c_index_reg),
        .wdata (c_rgba_reg),
        .raddr (c_addr_reg),
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // stage d: corner texels arrive; weight each channel
    // ---------------------------------------------------------------
    corner_wt_t [NUM_TAP-1:0] d_k_reg;

    always_ff @(posedge clk)
    begin
        if (d_free)
            d_k_reg <= c_k_reg;
    end

    logic [NUM_CH-1:0][NUM_TAP-1:0][PROD_W-1:0] d_prod_next;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            for (int t = 0; t < NUM_TAP; t++)
            begin
                d_prod_next[ch][t] = PROD_W'(d_k_reg[t])
                                   * PROD_W'(mem_rdata[t][TEXEL_W-CH_W*(ch+1) +: CH_W]);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage e: sum the four corners, keep the integer byte
    // ---------------------------------------------------------------
    logic [NUM_CH-1:0][NUM_TAP-1:0][PROD_W-1:0] e_prod_reg;

    always_ff @(posedge clk)
    begin
        if (e_free)
            e_prod_reg <= d_prod_next;
    end

    logic [NUM_CH-1:0][CH_W-1:0] e_pix_next;

    always_comb
    begin
        logic [SUM_W-1:0] acc;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            acc = '0;
            for (int t = 0; t < NUM_TAP; t++)
                acc = acc + SUM_W'(e_prod_reg[ch][t]);
            // truncation toward zero, the sum never reaches 256.0
            e_pix_next[ch] = acc[SUM_SHIFT +: CH_W];
        end
    end

    // ---------------------------------------------------------------
    // stage f: output register
    // ---------------------------------------------------------------
    logic [NUM_CH-1:0][CH_W-1:0] f_pix_reg;

    always_ff @(posedge clk)
    begin
        if (f_free)
            f_pix_reg <= e_pix_next;
    end

    // valid bits; a write item leaves the pipe once it has been stored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= sample_in.valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
            if (c_free)
                c_valid_reg <= b_valid_reg;
            if (d_free)
                d_valid_reg <= c_valid_reg && (c_action_reg == ACT_SAMPLE);
            if (e_free)
                e_valid_reg <= d_valid_reg;
            if (f_free)
                f_valid_reg <= e_valid_reg;
        end
    end

    assign pixel_out.valid = f_valid_reg;
    assign pixel_out.red   = f_pix_reg[CH_RED];
    assign pixel_out.green = f_pix_reg[CH_GREEN];
    assign pixel_out.blue  = f_pix_reg[CH_BLUE];
    assign pixel_out.alpha = f_pix_reg[CH_ALPHA];

endmodule

/* rtl/bts_checker.sv */
// port-level checker for the bilinear texture sampler, bound to the top level
`include "assert_macros.svh"

module bts_checker import bts_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_action,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CH_W-1:0] out_red,
    input logic [CH_W-1:0] out_green,
    input logic [CH_W-1:0] out_blue,
    input logic [CH_W-1:0] out_alpha
);

    // a stalled pixel stays put
    `BTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha), "stalled pixel changed or vanished")

    // with the output register free the whole pipe can move, so input is taken
    `BTS_ASSERT_IMPLY(a_ready_when_free, clk, rst_n, !out_valid || out_ready, in_ready, "input refused while output side free")

    // a sample reaches the output after passing the stage registers a to f in order when nothing stalls
    `BTS_ASSERT_NEXT(a_sample_latency, clk, rst_n, (in_valid && in_ready && in_action == ACT_SAMPLE && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "sample result missing after pipeline latency")

endmodule

bind bilinear_texture_sampler_core bts_checker u_bts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .in_action (sample_in.action),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .out_red   (pixel_out.red),
    .out_green (pixel_out.green),
    .out_blue  (pixel_out.blue),
    .out_alpha (pixel_out.alpha)
);
